// ----- rtl/fspi_pkg.sv -----
// ----------------------------------------------------------------------------
// fspi_pkg: shared types and constants for the five-stage pipeline interlock
// Holds the stage slot type, the scoreboard port types and the execute
// latency table.
// ----------------------------------------------------------------------------
package fspi_pkg;

  // Operation class that marks control flow.
  localparam logic [4:0] OP_CTRL = 5'd2;

  // One stage latch. An empty latch is all zeros.
  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [4:0]  op;
    logic [1:0]  nsrc;
    logic [5:0]  sa;
    logic [5:0]  sb;
    logic        hd;
    logic [5:0]  dst;
  } slot_t;

  // Enable and raw register index for one scoreboard access.
  typedef struct packed {
    logic       en;
    logic [5:0] idx;
  } sb_port_t;

  // Scoreboard status as seen after this cycle's writeback.
  typedef struct packed {
    logic busy_a;
    logic busy_b;
    logic wb_clear;
  } sb_stat_t;

  // Execute countdown reload value, indexed by operation class.
  function automatic logic [3:0] lat_m1(logic [4:0] op);
    logic [3:0] r;
    unique case (op)
      5'd8, 5'd10, 5'd12, 5'd14, 5'd15, 5'd18, 5'd21, 5'd22, 5'd23: r = 4'd1;
      5'd9, 5'd17, 5'd19: r = 4'd3;
      5'd20:              r = 4'd15;
      default:            r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/five_stage_pipeline_interlock_unit.sv -----
// ----------------------------------------------------------------------------
// five_stage_pipeline_interlock_unit: in-order pipeline interlock model
// Each item is one tick of a fetch, decode, execute, memory, writeback
// pipeline with a scoreboard, execute latencies and branch bubbles.
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                         content
//  s        in         s_tvalid s_tready s_tdata s_tuser  offered instruction
//  m        out        m_tvalid m_tready m_tdata          tick report
//
// Every accepted item is one pipeline tick, worked out combinationally from
// the stage latches and the scoreboard; an item can be taken every clock in
// which the output register is empty or being taken. Its report is written
// to the output register at the accepting edge.
// Reset empties all latches and the scoreboard at once.
module five_stage_pipeline_interlock_unit #(
  parameter int REG_COUNT = 64,
  parameter int OP_TYPES  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // inst_tag[15:0] op_type[20:16] num_sources[22:21] src_a[28:23]
  // src_b[34:29] has_dest[35] dest_reg[41:36], zero fill above
  input  logic [47:0] s_tdata,
  // offer_valid[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // offer_taken[0] retire_valid[1] retire_tag[17:2] data_hazard[18]
  // control_hazard[19] finished[20], zero fill above
  output logic [23:0] m_tdata
);

  fspi_pkg::slot_t fetch, decode, execute, memory;
  fspi_pkg::slot_t fetch_next, decode_next, execute_next, memory_next;
  fspi_pkg::slot_t offer;
  logic [3:0]      countdown, countdown_next, op_lat;
  logic            dep_hold, dep_hold_next, ds_wb;
  logic            br_hold, br_hold_next, cs_wb;
  logic            adv;
  logic            taken, rv, dh, ch, fin;
  logic [15:0]     rtag;

  fspi_pkg::sb_port_t wb, inc, rd_a, rd_b;
  fspi_pkg::sb_stat_t stat;

  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  always_comb begin
    offer.valid = s_tuser;
    offer.tag   = s_tdata[15:0];
    offer.op    = s_tdata[20:16];
    offer.nsrc  = s_tdata[22:21];
    offer.sa    = s_tdata[28:23];
    offer.sb    = s_tdata[34:29];
    offer.hd    = s_tdata[35];
    offer.dst   = s_tdata[41:36];
  end

  assign rd_a.en  = fetch.valid && (fetch.nsrc != 2'd0);
  assign rd_a.idx = fetch.sa;
  assign rd_b.en  = fetch.valid && fetch.nsrc[1];
  assign rd_b.idx = fetch.sb;
  assign wb.en    = memory.valid && memory.hd;
  assign wb.idx   = memory.dst;

  // Op classes beyond the configured count take the shortest execute latency.
  assign op_lat = (32'(decode.op) >= OP_TYPES) ? 4'd0 : fspi_pkg::lat_m1(decode.op);

  fspi_scoreboard #(
    .REG_COUNT(REG_COUNT)
  ) u_scoreboard (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .wb   (wb),
    .inc  (inc),
    .rd_a (rd_a),
    .rd_b (rd_b),
    .stat (stat)
  );

  always_comb begin
    // Writeback.
    rv    = memory.valid;
    rtag  = memory.valid ? memory.tag : 16'd0;
    cs_wb = br_hold && !(memory.valid && memory.op == fspi_pkg::OP_CTRL);
    ds_wb = dep_hold && !stat.wb_clear;

    // Memory.
    memory_next = execute;

    // Execute.
    if (countdown != 4'd0) begin
      countdown_next = countdown - 4'd1;
    end else if (decode.valid) begin
      countdown_next = op_lat;
    end else begin
      countdown_next = 4'd0;
    end
    execute_next = (countdown_next != 4'd0) ? '0 : decode;

    // Decode sees the scoreboard after this tick's writeback.
    dh            = 1'b0;
    ch            = 1'b0;
    dep_hold_next = ds_wb;
    br_hold_next  = cs_wb;
    decode_next   = decode;
    inc.en        = 1'b0;
    inc.idx       = fetch.dst;
    if (countdown_next == 4'd0) begin
      dh            = stat.busy_a || stat.busy_b;
      ch            = fetch.valid && (fetch.op == fspi_pkg::OP_CTRL);
      dep_hold_next = ds_wb || dh;
      br_hold_next  = cs_wb || ch;
      if (dep_hold_next) begin
        decode_next = '0;
      end else begin
        inc.en      = fetch.valid && fetch.hd;
        decode_next = fetch;
      end
    end

    // Fetch.
    fetch_next = fetch;
    taken      = 1'b0;
    fin        = 1'b0;
    priority if (countdown_next != 4'd0 || dep_hold_next) begin
      fetch_next = fetch;
    end else if (br_hold_next) begin
      fetch_next = '0;
    end else if (offer.valid) begin
      fetch_next = offer;
      taken      = 1'b1;
    end else begin
      fin = !fetch.valid && !decode_next.valid && !execute_next.valid &&
            !memory_next.valid;
      fetch_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch     <= '0;
      decode    <= '0;
      execute   <= '0;
      memory    <= '0;
      countdown <= 4'd0;
      dep_hold  <= 1'b0;
      br_hold   <= 1'b0;
    end else if (adv) begin
      fetch     <= fetch_next;
      decode    <= decode_next;
      execute   <= execute_next;
      memory    <= memory_next;
      countdown <= countdown_next;
      dep_hold  <= dep_hold_next;
      br_hold   <= br_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, fin, ch, dh, rtag, rv, taken};
    end
  end

  // An instruction held in execute leaves the execute latch empty.
  a_countdown_bubble: assert property (@(posedge clk) disable iff (rst)
    (countdown != 4'd0) |-> !execute.valid)
    else $error("execute latch valid while countdown runs");

  // A report never claims both an empty pipeline and a taken offer.
  a_fin_taken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[20] && m_tdata[0]))
    else $error("finished together with offer_taken");

  // Retire tag is zero whenever nothing retired.
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[17:2] == 16'd0))
    else $error("retire_tag nonzero without retirement");

  // A valid memory latch retires on the tick that advances it.
  a_retire: assert property (@(posedge clk) disable iff (rst)
    (adv && memory.valid) |=> (m_tdata[1] && m_tdata[17:2] == $past(memory.tag)))
    else $error("memory latch did not retire");

endmodule

// ----- rtl/fspi_scoreboard.sv -----
// ----------------------------------------------------------------------------
// fspi_scoreboard: per-register pending-writer scoreboard
// One cell per architectural register with a saturating two-bit count of
// writers in flight. A register is ready when its count is zero.
// ----------------------------------------------------------------------------
module fspi_scoreboard #(
  parameter int REG_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  fspi_pkg::sb_port_t wb,
  input  fspi_pkg::sb_port_t inc,
  input  fspi_pkg::sb_port_t rd_a,
  input  fspi_pkg::sb_port_t rd_b,
  output fspi_pkg::sb_stat_t stat
);

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int RAW_N = 64;

  // Register fields are six bits wide; this folds them onto the cells.
  logic [IDX_W-1:0] wrap_tab [RAW_N];

  for (genvar v = 0; v < RAW_N; v++) begin : g_wrap
    assign wrap_tab[v] = IDX_W'(v % REG_COUNT);
  end

  logic [IDX_W-1:0]     wb_i, inc_i, a_i, b_i;
  logic [REG_COUNT-1:0] busy_wb;
  logic [REG_COUNT-1:0] clr_hit;

  assign wb_i  = wrap_tab[wb.idx];
  assign inc_i = wrap_tab[inc.idx];
  assign a_i   = wrap_tab[rd_a.idx];
  assign b_i   = wrap_tab[rd_b.idx];

  for (genvar i = 0; i < REG_COUNT; i++) begin : g_cell
    logic [1:0] pending;
    logic [1:0] p_wb;
    logic       wb_sel;
    logic       inc_sel;

    assign wb_sel  = wb.en && (wb_i == IDX_W'(i));
    assign inc_sel = inc.en && (inc_i == IDX_W'(i));

    always_comb begin
      p_wb = pending;
      if (wb_sel && pending != 2'd0) begin
        p_wb = pending - 2'd1;
      end
    end

    assign busy_wb[i] = (p_wb != 2'd0);
    assign clr_hit[i] = wb_sel && (p_wb == 2'd0);

    always_ff @(posedge clk) begin
      if (rst) begin
        pending <= 2'd0;
      end else if (step) begin
        if (inc_sel && p_wb != 2'd3) begin
          pending <= p_wb + 2'd1;
        end else begin
          pending <= p_wb;
        end
      end
    end
  end

  assign stat.busy_a   = rd_a.en && busy_wb[a_i];
  assign stat.busy_b   = rd_b.en && busy_wb[b_i];
  assign stat.wb_clear = |clr_hit;

endmodule
